@@ hdl/cps_pkg.sv @@
package cps_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 33;
   localparam int KIND_W  = 2;

   // Codes carried in the request tuser field.
   localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   // A stored point: x in the upper half, y in the lower half.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_FETCH   = 7'b0000010,
      ST_COMPARE = 7'b0000100,
      ST_NREAD   = 7'b0001000,
      ST_NDIST   = 7'b0010000,
      ST_NWAIT   = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } walk_state_type;

   typedef enum logic [3:0] {
      DS_IDLE = 4'b0001,
      DS_SQX  = 4'b0010,
      DS_SQY  = 4'b0100,
      DS_SUM  = 4'b1000
   } dist_state_type;

endpackage

@@ hdl/closest_pair_strip_merge.sv @@
// Strip merge step of a closest-pair search over integer points.
// Request words carry a kind in tuser: load a left point, load a right
// point, or start with a squared bound. Both lists must arrive sorted by
// ascending y. Load words are taken while no walk runs; loads beyond
// MAX_POINTS per list are dropped. Unused kind codes are taken and ignored.
// A start word launches the merge walk; req_tready stays low until it
// ends. The walk steps along both lists and takes left-to-right distances;
// for each distance the single squaring unit makes one squarer pass for dx
// and one for dy. Each left point is paired with at most 2*NEIGHBOR_REACH
// right points. If a list is empty, the bound is sent back without a walk.
// Exactly one response word follows each start: the smallest squared
// distance, or the bound if nothing was closer. It sits in an output
// register until rsp_tready takes it; loads keep being taken meanwhile, and
// only a second walk that finishes before the first word is taken waits.
// Reset (synchronous, active high) empties both lists and drops any
// pending response. Both lists are emptied after each start.
module closest_pair_strip_merge #(
   parameter int MAX_POINTS     = 256,
   parameter int NEIGHBOR_REACH = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // x [15:0], y [31:16], bound_sq [64:32], zero pad
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // best_sq [32:0], zero pad
);

   localparam int CW = $clog2(MAX_POINTS + 1);   // counts up to MAX_POINTS
   localparam int AW = $clog2(MAX_POINTS);       // store address
   localparam int SW = CW + 4;                   // room for index plus reach
   localparam int DW = cps_pkg::DIST_W;

   cps_pkg::walk_state_type state_ff, state_in;
   logic [CW-1:0] lcount_ff, lcount_in, rcount_ff, rcount_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, stop_ff, stop_in;
   logic [DW-1:0] best_ff, best_in, rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic               req_accept;
   cps_pkg::point_type req_point, left_pt, right_pt;
   logic               lwr_en, rwr_en, lrd_en, rrd_en;
   logic [CW-1:0]      rrd_addr;
   logic               dist_start, dist_done;
   logic [DW-1:0]      pair_dist;
   logic [CW-1:0]      i_next, j_next, k_next;
   logic [SW-1:0]      j_wide, reach_wide, stop_sum;
   logic [CW-1:0]      k_first, k_stop;

   assign req_tready = (state_ff == cps_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_point  = {req_tdata[15:0], req_tdata[31:16]};

   cps_store #(.DEPTH(MAX_POINTS)) u_left (
      .clock   (clock),
      .wr_en   (lwr_en),
      .wr_addr (lcount_ff[AW-1:0]),
      .wr_data (req_point),
      .rd_en   (lrd_en),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (left_pt)
   );

   cps_store #(.DEPTH(MAX_POINTS)) u_right (
      .clock   (clock),
      .wr_en   (rwr_en),
      .wr_addr (rcount_ff[AW-1:0]),
      .wr_data (req_point),
      .rd_en   (rrd_en),
      .rd_addr (rrd_addr[AW-1:0]),
      .rd_data (right_pt)
   );

   cps_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (dist_start),
      .p       (left_pt),
      .q       (right_pt),
      .done    (dist_done),
      .dist_sq (pair_dist)
   );

   assign i_next = i_ff + 1'b1;
   assign j_next = j_ff + 1'b1;
   assign k_next = k_ff + 1'b1;

   // Window of right points around j, clipped to the list. It always holds
   // j itself, so at least one distance is taken per left point that stops at j.
   assign j_wide     = SW'(j_ff);
   assign reach_wide = SW'(NEIGHBOR_REACH);
   assign stop_sum   = j_wide + reach_wide;
   assign k_first    = (j_wide >= reach_wide) ? CW'(j_wide - reach_wide) : '0;
   assign k_stop     = (stop_sum < SW'(rcount_ff)) ? CW'(stop_sum) : rcount_ff;

   always_comb begin
      state_in     = state_ff;
      lcount_in    = lcount_ff;
      rcount_in    = rcount_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      stop_in      = stop_ff;
      best_in      = best_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      lwr_en       = 1'b0;
      rwr_en       = 1'b0;
      lrd_en       = 1'b0;
      rrd_en       = 1'b0;
      rrd_addr     = j_ff;
      dist_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         cps_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  cps_pkg::KIND_LEFT: begin
                     if (lcount_ff < CW'(MAX_POINTS)) begin
                        lwr_en    = 1'b1;
                        lcount_in = lcount_ff + 1'b1;
                     end
                  end
                  cps_pkg::KIND_RIGHT: begin
                     if (rcount_ff < CW'(MAX_POINTS)) begin
                        rwr_en    = 1'b1;
                        rcount_in = rcount_ff + 1'b1;
                     end
                  end
                  cps_pkg::KIND_START: begin
                     best_in = req_tdata[64:32];
                     i_in    = '0;
                     j_in    = '0;
                     if (lcount_ff == '0 || rcount_ff == '0) begin
                        state_in = cps_pkg::ST_FINISH;
                     end else begin
                        state_in = cps_pkg::ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         cps_pkg::ST_FETCH: begin
            lrd_en   = 1'b1;
            rrd_en   = 1'b1;
            rrd_addr = j_ff;
            state_in = cps_pkg::ST_COMPARE;
         end
         cps_pkg::ST_COMPARE: begin
            if (left_pt.y <= right_pt.y) begin
               k_in     = k_first;
               stop_in  = k_stop;
               state_in = cps_pkg::ST_NREAD;
            end else begin
               j_in     = j_next;
               state_in = (j_next == rcount_ff) ? cps_pkg::ST_FINISH : cps_pkg::ST_FETCH;
            end
         end
         cps_pkg::ST_NREAD: begin
            rrd_en   = 1'b1;
            rrd_addr = k_ff;
            state_in = cps_pkg::ST_NDIST;
         end
         cps_pkg::ST_NDIST: begin
            dist_start = 1'b1;
            state_in   = cps_pkg::ST_NWAIT;
         end
         cps_pkg::ST_NWAIT: begin
            if (dist_done) begin
               if (pair_dist < best_ff) begin
                  best_in = pair_dist;
               end
               k_in = k_next;
               if (k_next < stop_ff) begin
                  state_in = cps_pkg::ST_NREAD;
               end else begin
                  i_in     = i_next;
                  state_in = (i_next == lcount_ff) ? cps_pkg::ST_FINISH
                                                   : cps_pkg::ST_FETCH;
               end
            end
         end
         cps_pkg::ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = best_ff;
               rsp_valid_in = 1'b1;
               lcount_in    = '0;
               rcount_in    = '0;
               state_in     = cps_pkg::ST_IDLE;
            end
         end
         default: state_in = cps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cps_pkg::ST_IDLE;
         lcount_ff    <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcount_ff    <= lcount_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      stop_ff     <= stop_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};

endmodule

@@ hdl/cps_store.sv @@
module cps_store #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  cps_pkg::point_type    wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output cps_pkg::point_type    rd_data
);

   cps_pkg::point_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/cps_dist.sv @@
module cps_dist (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  cps_pkg::point_type           p,
   input  cps_pkg::point_type           q,
   output logic                         done,
   output logic [cps_pkg::DIST_W-1:0]   dist_sq
);

   localparam int CW = cps_pkg::COORD_W;

   cps_pkg::dist_state_type state_ff, state_in;
   logic [CW-1:0]                dx_ff, dx_in, dy_ff, dy_in;
   logic [2*CW-1:0]              acc_ff, acc_in, prod_ff, prod_in;
   logic [cps_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic                         done_ff, done_in;
   logic signed [CW:0]           diff_x, diff_y;
   logic [CW:0]                  abs_x, abs_y;
   logic [CW-1:0]                mul_op;
   logic [2*CW-1:0]              mul_out;

   // Differences of two signed coordinates need one extra bit; their
   // magnitude always fits back into the coordinate width.
   assign diff_x = {p.x[CW-1], p.x} - {q.x[CW-1], q.x};
   assign diff_y = {p.y[CW-1], p.y} - {q.y[CW-1], q.y};
   assign abs_x  = diff_x[CW] ? -diff_x : diff_x;
   assign abs_y  = diff_y[CW] ? -diff_y : diff_y;

   // The single squarer serves dx and then dy.
   assign mul_op  = (state_ff == cps_pkg::DS_SQY) ? dy_ff : dx_ff;
   assign mul_out = mul_op * mul_op;

   always_comb begin
      state_in = state_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      dist_in  = dist_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         cps_pkg::DS_IDLE: begin
            if (start) begin
               dx_in    = abs_x[CW-1:0];
               dy_in    = abs_y[CW-1:0];
               state_in = cps_pkg::DS_SQX;
            end
         end
         cps_pkg::DS_SQX: begin
            acc_in   = mul_out;
            state_in = cps_pkg::DS_SQY;
         end
         cps_pkg::DS_SQY: begin
            prod_in  = mul_out;
            state_in = cps_pkg::DS_SUM;
         end
         cps_pkg::DS_SUM: begin
            dist_in  = {1'b0, acc_ff} + {1'b0, prod_ff};
            done_in  = 1'b1;
            state_in = cps_pkg::DS_IDLE;
         end
         default: state_in = cps_pkg::DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cps_pkg::DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      dist_ff <= dist_in;
   end

   assign done    = done_ff;
   assign dist_sq = dist_ff;

endmodule
